>>> hdl/cal_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types and constants for the cursor array list: request and response
// payloads, action and status codes, controller states and memory commands.
// ----------------------------------------------------------------------------
package cal_pkg;

  // Capacity of the list, the address width derived from it, and the other widths.
  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = 5;
  localparam int DW    = 32;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_START  = 3'd2,
    ACT_LAST   = 3'd3,
    ACT_PREV   = 3'd4,
    ACT_NEXT   = 3'd5,
    ACT_POS    = 3'd6,
    ACT_READ   = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY_SLOT = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PUT,
    S_RESULT
  } state_t;

  typedef struct packed {
    act_t                   action;
    logic signed [DW-1:0]   value;
    logic        [CW-1:0]   position;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0]   data;
    status_t                status;
    logic        [CW-1:0]   count;
    logic        [CW-1:0]   cursor;
  } rsp_t;

  // Memory command from the controller: write enable, write address and data, read address.
  typedef struct packed {
    logic            we;
    logic [AW-1:0]   waddr;
    logic [DW-1:0]   wdata;
    logic [AW-1:0]   raddr;
  } mem_cmd_t;

endpackage
`default_nettype wire

>>> hdl/cal_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cal_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module cal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/cal_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cal_ctrl
// Sequencer for the list: holds count and cursor, decodes each request and
// walks the element memory one slot per cycle for insert and remove shifts.
// ----------------------------------------------------------------------------
module cal_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_ready,
  input  wire cal_pkg::req_t               req,
  output cal_pkg::mem_cmd_t                mem_cmd,
  input  wire logic [cal_pkg::DW-1:0]      mem_rdata,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output cal_pkg::rsp_t                    res
);
  import cal_pkg::*;

  state_t             state, state_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      cursor;
  logic [AW-1:0]      idx;
  act_t               op;
  logic signed [DW-1:0] val;
  logic [DW-1:0]      data;
  status_t            status;

  logic               accept;
  logic               full;
  logic               at_end;
  logic               more_dn;
  logic               fetch_more;

  assign accept     = req_valid && req_ready;
  assign full       = count >= CW'(DEPTH);
  assign at_end     = cursor >= count;
  assign more_dn    = (CW'(idx) + CW'(1)) < count;
  assign fetch_more = (cursor + CW'(1)) < count;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req.action)
            ACT_INSERT: begin
              if (full) begin
                state_next = S_RESULT;
              end else if (cursor == count) begin
                state_next = S_PUT;
              end else begin
                state_next = S_SHIFT_UP;
              end
            end
            ACT_REMOVE, ACT_READ: begin
              state_next = at_end ? S_RESULT : S_FETCH;
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (op == ACT_READ || !fetch_more) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_SHIFT_DN;
        end
      end
      S_SHIFT_UP: begin
        if (CW'(idx) == cursor) begin
          state_next = S_PUT;
        end
      end
      S_SHIFT_DN: begin
        if (!more_dn) begin
          state_next = S_RESULT;
        end
      end
      S_PUT: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Handshake and memory commands.
  always_comb begin
    req_ready     = state == S_IDLE;
    res_valid     = state == S_RESULT;
    mem_cmd.we    = 1'b0;
    mem_cmd.waddr = idx;
    mem_cmd.wdata = mem_rdata;
    mem_cmd.raddr = idx;
    case (state)
      S_IDLE: begin
        if (req.action == ACT_INSERT) begin
          mem_cmd.raddr = AW'(count - CW'(1));
        end else begin
          mem_cmd.raddr = AW'(cursor);
        end
      end
      S_FETCH: begin
        mem_cmd.raddr = AW'(cursor + CW'(1));
      end
      S_SHIFT_UP: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = idx + AW'(1);
        mem_cmd.raddr = idx - AW'(1);
      end
      S_SHIFT_DN: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = idx - AW'(1);
        mem_cmd.raddr = idx + AW'(1);
      end
      S_PUT: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = AW'(cursor);
        mem_cmd.wdata = val;
      end
      default: begin
        mem_cmd.we = 1'b0;
      end
    endcase
  end

  assign res.data   = data;
  assign res.status = status;
  assign res.count  = count;
  assign res.cursor = cursor;

  // State register and list bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      cursor <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (req.action)
          ACT_START: cursor <= '0;
          ACT_LAST:  cursor <= (count != '0) ? count - CW'(1) : '0;
          ACT_PREV:  if (cursor != '0) cursor <= cursor - CW'(1);
          ACT_NEXT:  if (cursor < count) cursor <= cursor + CW'(1);
          ACT_POS:   if (req.position <= count) cursor <= req.position;
          default: begin
          end
        endcase
      end
      if (state == S_PUT) begin
        count <= count + CW'(1);
      end
      if ((state == S_FETCH && op == ACT_REMOVE && !fetch_more) ||
          (state == S_SHIFT_DN && !more_dn)) begin
        count <= count - CW'(1);
      end
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req.action;
      val    <= req.value;
      data   <= '0;
      idx    <= AW'(count - CW'(1));
      case (req.action)
        ACT_INSERT:           status <= full ? ST_FULL : ST_OK;
        ACT_REMOVE, ACT_READ: status <= at_end ? ST_EMPTY_SLOT : ST_OK;
        ACT_POS:              status <= (req.position > count) ? ST_RANGE : ST_OK;
        default:              status <= ST_OK;
      endcase
    end
    case (state)
      S_FETCH: begin
        data <= mem_rdata;
        idx  <= AW'(cursor + CW'(1));
      end
      S_SHIFT_UP: idx <= idx - AW'(1);
      S_SHIFT_DN: idx <= idx + AW'(1);
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/cursor_array_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_array_list
// Ordered list of up to DEPTH signed 32-bit values with a cursor, kept in
// one element memory, one response per request.
// ----------------------------------------------------------------------------
// The block serves one request at a time and answers each with one response
// that carries the data, a status, the element count and the cursor. For an
// insert or a remove, the elements behind the cursor move through the
// element memory one slot per cycle, read on its read port and written back
// one slot over on its write port. A finished response waits in an output
// register, and the next request is taken while it waits.
module cursor_array_list (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire cal_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output cal_pkg::rsp_t       rsp
);
  import cal_pkg::*;

  mem_cmd_t        mem_cmd;
  logic [DW-1:0]   mem_rdata;
  logic            res_valid;
  logic            res_ready;
  rsp_t            res;

  cal_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_cmd.we),
    .waddr (mem_cmd.waddr),
    .wdata (mem_cmd.wdata),
    .raddr (mem_cmd.raddr),
    .rdata (mem_rdata)
  );

  cal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .mem_cmd   (mem_cmd),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: loads whenever it is empty or being drained.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule
`default_nettype wire

>>> hdl/cal_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cal_checker
// Port-level checks for the cursor array list, bound to the top level.
// ----------------------------------------------------------------------------
module cal_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire cal_pkg::rsp_t  rsp
);
  import cal_pkg::*;

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.count <= CW'(DEPTH))
    else $error("count above capacity");

  // The cursor stays within 0..count.
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.cursor <= rsp.count)
    else $error("cursor beyond end of list");

  // A full status is reported only on a full list.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> rsp.count == CW'(DEPTH))
    else $error("full status on a list with room");

  // Failed requests return zero data.
  a_fail_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> rsp.data == '0)
    else $error("nonzero data on a failed request");

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("response changed while stalled");

endmodule

bind cursor_array_list cal_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire

>>> tb/sv/cal_list_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cal_list_checker
// Watches both channels of the cursor array list and checks every response.
// It keeps its own copy of the list, its length and the cursor. Each accepted
// request is applied to that copy and the predicted response is queued. Each
// accepted response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cal_list_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire logic           req_ready,
  input  wire cal_pkg::req_t  req,
  input  wire logic           rsp_valid,
  input  wire logic           rsp_ready,
  input  wire cal_pkg::rsp_t  rsp,
  output int                  err_count,
  output int                  open_count
);
  import cal_pkg::*;

  // Shadow copy of the list contents, its length and the cursor.
  logic signed [DW-1:0] list_mem [DEPTH];
  int                   list_len;
  int                   cur_pos;

  // Predicted responses, oldest first.
  rsp_t                 pending_rsp_q[$];

  // Applies one request to the shadow list and returns the response it earns.
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int   i;
    o        = '0;
    o.status = ST_OK;
    case (r.action)
      ACT_INSERT: begin
        if (list_len >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          for (i = list_len; i > cur_pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[cur_pos] = r.value;
          list_len++;
        end
      end
      ACT_REMOVE: begin
        if (cur_pos >= list_len) begin
          o.status = ST_EMPTY_SLOT;
        end else begin
          o.data = list_mem[cur_pos];
          for (i = cur_pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      ACT_START: begin
        cur_pos = 0;
      end
      ACT_LAST: begin
        cur_pos = (list_len > 0) ? list_len - 1 : 0;
      end
      ACT_PREV: begin
        if (cur_pos > 0) cur_pos--;
      end
      ACT_NEXT: begin
        if (cur_pos < list_len) cur_pos++;
      end
      ACT_POS: begin
        if (int'(r.position) > list_len) o.status = ST_RANGE;
        else cur_pos = int'(r.position);
      end
      default: begin
        // Read of the element under the cursor.
        if (cur_pos >= list_len) o.status = ST_EMPTY_SLOT;
        else o.data = list_mem[cur_pos];
      end
    endcase
    o.count  = CW'(list_len);
    o.cursor = CW'(cur_pos);
    return o;
  endfunction

  // Responses are retired before requests are queued, since a response
  // accepted at an edge can never belong to the request taken at that edge.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      list_len = 0;
      cur_pos  = 0;
      pending_rsp_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("unexpected response: data %0d status %0d count %0d cursor %0d",
                 rsp.data, rsp.status, rsp.count, rsp.cursor);
          err_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, rsp.data);
            err_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            err_count++;
          end
          if (rsp.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, rsp.count);
            err_count++;
          end
          if (rsp.cursor !== want.cursor) begin
            $error("cursor: expected %0d, got %0d", want.cursor, rsp.cursor);
            err_count++;
          end
        end
      end
      if (req_valid && req_ready) pending_rsp_q.push_back(apply_request(req));
    end
    open_count = pending_rsp_q.size();
  end

endmodule
`default_nettype wire

>>> tb/sv/cursor_array_list_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_array_list_tb
// Stimulus and verdict for the cursor array list.
// A directed opening walks the empty and full corners and the value extremes,
// then random requests run in growing, shrinking and mixed stretches so the
// list fills and drains many times. Both sides stall at random; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module cursor_array_list_tb;
  import cal_pkg::*;

  localparam int RANDOM_REQS = 1750;
  localparam int MODE_SPAN   = 32;
  localparam int DRAIN_WAIT  = 24;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;
  int   err_count;
  int   open_count;

  // Request mixes used by the random part.
  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BLEND
  } mix_t;

  act_t move_acts [6] = '{ACT_START, ACT_LAST, ACT_PREV, ACT_NEXT, ACT_POS, ACT_READ};
  bit   req_steady;

  cursor_array_list DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  cal_list_checker list_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .err_count  (err_count),
    .open_count (open_count)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic req_t make_req(act_t a, logic signed [DW-1:0] v, logic [CW-1:0] p);
    req_t r;
    r.action   = a;
    r.value    = v;
    r.position = p;
    return r;
  endfunction

  function automatic logic signed [DW-1:0] pick_value();
    logic signed [DW-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 15))
      0:       v = {1'b0, {(DW-1){1'b1}}};
      1:       v = {1'b1, {(DW-1){1'b0}}};
      2:       v = '1;
      3:       v = '0;
      default: ;
    endcase
    return v;
  endfunction

  // Mostly positions near the live range, sometimes anything the field holds.
  function automatic logic [CW-1:0] pick_position();
    if ($urandom_range(0, 7) == 0) return CW'($urandom_range(0, 31));
    return CW'($urandom_range(0, DEPTH + 1));
  endfunction

  function automatic act_t pick_action(mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (roll < 55) return ACT_INSERT;
        if (roll < 62) return ACT_REMOVE;
      end
      MIX_SHRINK: begin
        if (roll < 55) return ACT_REMOVE;
        if (roll < 62) return ACT_INSERT;
      end
      default: begin
        if (roll < 12) return ACT_INSERT;
        if (roll < 24) return ACT_REMOVE;
      end
    endcase
    return move_acts[roll % 6];
  endfunction

  // Presents one request after a random gap and holds it until it is taken.
  // Valid is only lowered when a gap follows, so it never toggles in a step.
  task automatic send_request(req_t r);
    int gap;
    if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
    gap = req_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  // Response side: a random stall before each response is taken.
  initial begin : rsp_side
    int gap;
    bit steady;
    rsp_ready = 1'b0;
    steady    = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // Request side: reset, directed corners, random stretches, then the verdict.
  initial begin : req_side
    mix_t                 mix;
    logic signed [DW-1:0] v;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    req_steady = 1'b0;
    mix        = MIX_GROW;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty list corners.
    send_request(make_req(ACT_READ, '0, '0));
    send_request(make_req(ACT_REMOVE, '0, '0));
    send_request(make_req(ACT_LAST, '0, '0));
    send_request(make_req(ACT_PREV, '0, '0));
    send_request(make_req(ACT_NEXT, '0, '0));
    send_request(make_req(ACT_POS, '0, CW'(1)));

    // Fill the list at the front, starting with the value extremes.
    for (int k = 0; k < DEPTH; k++) begin
      case (k)
        0:       v = {1'b0, {(DW-1){1'b1}}};
        1:       v = {1'b1, {(DW-1){1'b0}}};
        2:       v = '1;
        3:       v = '0;
        default: v = $urandom;
      endcase
      send_request(make_req(ACT_INSERT, v, pick_position()));
    end

    // Full list corners, cursor at the end slot, then a remove at the tail.
    send_request(make_req(ACT_INSERT, pick_value(), '0));
    send_request(make_req(ACT_POS, '0, CW'(DEPTH)));
    send_request(make_req(ACT_NEXT, '0, '0));
    send_request(make_req(ACT_READ, '0, '0));
    send_request(make_req(ACT_LAST, '0, '0));
    send_request(make_req(ACT_REMOVE, '0, '0));
    send_request(make_req(ACT_START, '0, '0));

    // Random stretches that grow, shrink or mix the list.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % MODE_SPAN == 0) begin
        case ($urandom_range(0, 2))
          0:       mix = MIX_GROW;
          1:       mix = MIX_SHRINK;
          default: mix = MIX_BLEND;
        endcase
      end
      send_request(make_req(pick_action(mix), pick_value(), pick_position()));
    end
    req_valid <= 1'b0;

    // Drain outstanding responses, then let the block settle.
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
